@@ design/bblur_pkg.sv @@
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared constants, register indexes and payload types of the box blur
// line pass.
// ----------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int MEAN_BITS       = 16;
	localparam int RADIUS_BITS     = 4;
	localparam int RECIP_BITS      = 17;
	localparam int FRAC_BITS       = 16;
	localparam int ROUND_HALF      = 32768;
	localparam int JOB_QUEUE_DEPTH = 2;

	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;
	localparam int REG_INDEX_BITS = 1;

	localparam logic [REG_INDEX_BITS-1:0] REG_RADIUS = 1'b0;
	localparam logic [REG_INDEX_BITS-1:0] REG_RECIP  = 1'b1;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd1;
	localparam logic [RECIP_BITS-1:0]  RECIP_RESET  = 17'd21845;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   line_end;
	} item_t;

	typedef struct packed {
		logic [MEAN_BITS-1:0] mean_value;
		logic                 line_done;
	} result_t;

endpackage

`default_nettype wire

@@ design/box_blur_line_pass.sv @@
// ----------------------------------------------------------------------------
// box_blur_line_pass
// A job leaves the back end's idle state, waits for a free result path, then
// sweeps its taps through the accumulate loop (one buffer read a tap) before
// the product and result registers; a job without a result ends in idle.
// Samples are taken while the two-entry job queue has room.
// Reset clears control state and loads radius 1, reciprocal 21845; the sample
// buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_line_pass #(
	parameter int MAX_RADIUS = 15
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [bblur_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [bblur_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [bblur_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                      pready,
	input  wire logic                                 item_valid,
	output logic                                      item_ready,
	input  wire bblur_pkg::item_t                     item,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output bblur_pkg::result_t                        result
);

	localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
	localparam int LPOS_W    = $clog2(WIN_DEPTH + 1);
	localparam int PTR_W     = $clog2(WIN_DEPTH + bblur_pkg::JOB_QUEUE_DEPTH + 1);
	localparam int BUF_DEPTH = 1 << PTR_W;
	localparam int JOB_W     = PTR_W + LPOS_W + bblur_pkg::SAMPLE_BITS + 2 * RAD_W + 2;
	localparam int DW        = bblur_pkg::APB_DATA_BITS;

	logic [bblur_pkg::RADIUS_BITS-1:0]    radius_q;
	logic [bblur_pkg::RECIP_BITS-1:0]     recip_q;
	logic                                 cfg_wr;
	logic [bblur_pkg::REG_INDEX_BITS-1:0] reg_idx;

	logic                                 wr_en;
	logic [PTR_W-1:0]                     wr_addr;
	logic [bblur_pkg::SAMPLE_BITS-1:0]    wr_data;
	logic [PTR_W-1:0]                     rd_addr;
	logic [bblur_pkg::SAMPLE_BITS-1:0]    rd_data;
	logic                                 job_full;
	logic                                 job_push;
	logic [JOB_W-1:0]                     job_front;
	logic                                 job_pop;
	logic                                 job_valid;
	logic [JOB_W-1:0]                     job_head;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[bblur_pkg::APB_ADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bblur_pkg::RADIUS_RESET;
			recip_q  <= bblur_pkg::RECIP_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				bblur_pkg::REG_RADIUS: radius_q <= pwdata[bblur_pkg::RADIUS_BITS-1:0];
				bblur_pkg::REG_RECIP:  recip_q  <= pwdata[bblur_pkg::RECIP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bblur_pkg::REG_RADIUS: prdata = DW'(radius_q);
			bblur_pkg::REG_RECIP:  prdata = DW'(recip_q);
			default:               prdata = '0;
		endcase
	end

	bblur_front #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.radius     (radius_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.job_full   (job_full),
		.job_push   (job_push),
		.job        (job_front)
	);

	bblur_ram #(
		.WIDTH (bblur_pkg::SAMPLE_BITS),
		.DEPTH (BUF_DEPTH)
	) u_sample_buf (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bblur_job_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (bblur_pkg::JOB_QUEUE_DEPTH)
	) u_job_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_data  (job_front),
		.full       (job_full),
		.pop        (job_pop),
		.head_valid (job_valid),
		.head_data  (job_head)
	);

	bblur_back #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.recip        (recip_q),
		.job_valid    (job_valid),
		.job          (job_head),
		.job_pop      (job_pop),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ design/bblur_ram.sv @@
// ----------------------------------------------------------------------------
// bblur_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/bblur_job_fifo.sv @@
// ----------------------------------------------------------------------------
// bblur_job_fifo
// Short register queue that carries classified jobs from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_job_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output logic      [WIDTH-1:0] head_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("job queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job pushed into full queue");

endmodule

`default_nettype wire

@@ design/bblur_front.sv @@
// ----------------------------------------------------------------------------
// bblur_front
// Accepts samples, stores them in the sample buffer, tracks line position
// and first sample, and classifies each sample into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_front #(
	parameter int MAX_RADIUS = 15
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [bblur_pkg::RADIUS_BITS-1:0]    radius,
	input  wire logic                                 item_valid,
	output logic                                      item_ready,
	input  wire bblur_pkg::item_t                     item,
	output logic                                      wr_en,
	output logic [$clog2(2*MAX_RADIUS+2+bblur_pkg::JOB_QUEUE_DEPTH)-1:0] wr_addr,
	output logic [bblur_pkg::SAMPLE_BITS-1:0]         wr_data,
	input  wire logic                                 job_full,
	output logic                                      job_push,
	output logic [$clog2(2*MAX_RADIUS+2+bblur_pkg::JOB_QUEUE_DEPTH)
		+ $clog2(2*MAX_RADIUS+2) + bblur_pkg::SAMPLE_BITS
		+ 2*$clog2(MAX_RADIUS+1) + 1 : 0]            job
);

	localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
	localparam int LPOS_W    = $clog2(WIN_DEPTH + 1);
	localparam int PTR_W     = $clog2(WIN_DEPTH + bblur_pkg::JOB_QUEUE_DEPTH + 1);
	localparam int SB        = bblur_pkg::SAMPLE_BITS;

	typedef struct packed {
		logic [PTR_W-1:0]  ptr;
		logic [LPOS_W-1:0] lpos;
		logic [SB-1:0]     first;
		logic [RAD_W-1:0]  r;
		logic [RAD_W-1:0]  e_start;
		logic              has_out;
		logic              is_end;
	} job_t;

	logic [LPOS_W-1:0] lpos_q;
	logic [SB-1:0]     first_q;
	logic [PTR_W-1:0]  wp_q;

	logic              accept;
	logic [RAD_W-1:0]  r_eff;
	logic [LPOS_W-1:0] lp_new;
	logic [LPOS_W-1:0] lp_last;
	logic [SB-1:0]     first_new;
	job_t              job_d;

	assign item_ready = !job_full;
	assign accept     = item_valid && item_ready;

	always_comb begin
		r_eff     = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius);
		lp_new    = (lpos_q < LPOS_W'(WIN_DEPTH)) ? lpos_q + LPOS_W'(1) : lpos_q;
		lp_last   = lp_new - LPOS_W'(1);
		first_new = (lpos_q == '0) ? item.sample : first_q;

		job_d.ptr    = wp_q;
		job_d.lpos   = lp_new;
		job_d.first  = first_new;
		job_d.r      = r_eff;
		job_d.is_end = item.line_end;
		if (item.line_end) begin
			job_d.has_out = 1'b1;
			job_d.e_start = (lp_last < LPOS_W'(r_eff)) ? RAD_W'(lp_last) : r_eff;
		end else begin
			job_d.has_out = (lp_new > LPOS_W'(r_eff));
			job_d.e_start = r_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q  <= '0;
			first_q <= '0;
			wp_q    <= '0;
		end else if (accept) begin
			lpos_q  <= item.line_end ? '0 : lp_new;
			first_q <= first_new;
			wp_q    <= wp_q + PTR_W'(1);
		end
	end

	assign wr_en    = accept;
	assign wr_addr  = wp_q;
	assign wr_data  = item.sample;
	assign job_push = accept;
	assign job      = job_d;

endmodule

`default_nettype wire

@@ design/bblur_back.sv @@
// ----------------------------------------------------------------------------
// bblur_back
// Runs jobs: sweeps the window taps through the sample buffer, accumulates
// the sum, scales by the reciprocal, rounds, saturates and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_back #(
	parameter int MAX_RADIUS = 15
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [bblur_pkg::RECIP_BITS-1:0]     recip,
	input  wire logic                                 job_valid,
	input  wire logic [$clog2(2*MAX_RADIUS+2+bblur_pkg::JOB_QUEUE_DEPTH)
		+ $clog2(2*MAX_RADIUS+2) + bblur_pkg::SAMPLE_BITS
		+ 2*$clog2(MAX_RADIUS+1) + 1 : 0]            job,
	output logic                                      job_pop,
	output logic [$clog2(2*MAX_RADIUS+2+bblur_pkg::JOB_QUEUE_DEPTH)-1:0] rd_addr,
	input  wire logic [bblur_pkg::SAMPLE_BITS-1:0]    rd_data,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output bblur_pkg::result_t                        result
);

	localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
	localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
	localparam int LPOS_W    = $clog2(WIN_DEPTH + 1);
	localparam int PTR_W     = $clog2(WIN_DEPTH + bblur_pkg::JOB_QUEUE_DEPTH + 1);
	localparam int SB        = bblur_pkg::SAMPLE_BITS;
	localparam int KW        = RAD_W + 2;
	localparam int SUM_W     = SB + $clog2(WIN_DEPTH + 1);
	localparam int PROD_W    = SUM_W + bblur_pkg::RECIP_BITS;
	localparam int RND_W     = PROD_W + 1;
	localparam int MB        = bblur_pkg::MEAN_BITS;
	localparam int FB        = bblur_pkg::FRAC_BITS;

	typedef struct packed {
		logic [PTR_W-1:0]  ptr;
		logic [LPOS_W-1:0] lpos;
		logic [SB-1:0]     first;
		logic [RAD_W-1:0]  r;
		logic [RAD_W-1:0]  e_start;
		logic              has_out;
		logic              is_end;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WAIT = 3'b010,
		ST_TAP  = 3'b100
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [RAD_W-1:0]   e_q;
	logic [RAD_W:0]     t_q;

	logic               tap_vld_s1;
	logic               first_s1;
	logic               last_s1;
	logic               use_first_s1;
	logic               done_s1;
	logic [SB-1:0]      fsamp_s1;

	logic [SUM_W-1:0]   acc_q;
	logic               sum_vld_s2;
	logic               done_s2;

	logic [PROD_W-1:0]  prod_s3;
	logic               prod_vld_s3;
	logic               done_s3;

	bblur_pkg::result_t res_q;
	logic               res_vld_q;

	job_t               job_in;
	logic               in_flight;
	logic               path_free;
	logic [RAD_W:0]     two_r;
	logic               tap_last;
	logic [KW-1:0]      k_raw;
	logic [RAD_W:0]     k_cl;
	logic               use_first;
	logic [SB-1:0]      sample_val;
	logic [SUM_W-1:0]   acc_next;
	logic [RND_W-1:0]   rnd;
	logic [MB-1:0]      mean;

	always_comb begin
		job_in     = job_t'(job);
		in_flight  = (tap_vld_s1 && last_s1) || sum_vld_s2 || prod_vld_s3;
		path_free  = !in_flight && (!res_vld_q || result_ready);
		two_r      = {job_q.r, 1'b0};
		tap_last   = (t_q == two_r);
		k_raw      = KW'(e_q) + KW'(job_q.r) - KW'(t_q);
		k_cl       = k_raw[KW-1] ? '0 : k_raw[RAD_W:0];
		use_first  = (LPOS_W'(k_cl) >= job_q.lpos);
		rd_addr    = job_q.ptr - PTR_W'(k_cl);
		job_pop    = (state_q == ST_IDLE) && job_valid;
		sample_val = use_first_s1 ? fsamp_s1 : rd_data;
		acc_next   = (first_s1 ? '0 : acc_q) + SUM_W'(sample_val);
		rnd        = {1'b0, prod_s3} + RND_W'(bblur_pkg::ROUND_HALF);
		mean       = (|rnd[RND_W-1:FB+MB]) ? {MB{1'b1}} : rnd[FB+MB-1:FB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q     <= '0;
			t_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						e_q     <= job_in.e_start;
						t_q     <= '0;
						state_q <= job_in.has_out ? ST_WAIT : ST_IDLE;
					end
				end
				ST_WAIT: begin
					if (path_free) begin
						state_q <= ST_TAP;
					end
				end
				ST_TAP: begin
					if (tap_last) begin
						t_q <= '0;
						if (job_q.is_end && (e_q != '0)) begin
							e_q     <= e_q - RAD_W'(1);
							state_q <= ST_WAIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						t_q <= t_q + (RAD_W+1)'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_s1  <= 1'b0;
			sum_vld_s2  <= 1'b0;
			prod_vld_s3 <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			tap_vld_s1  <= (state_q == ST_TAP);
			sum_vld_s2  <= tap_vld_s1 && last_s1;
			prod_vld_s3 <= sum_vld_s2;
			if (prod_vld_s3) begin
				res_vld_q <= 1'b1;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1     <= (t_q == '0);
		last_s1      <= tap_last;
		use_first_s1 <= use_first;
		done_s1      <= job_q.is_end && (e_q == '0);
		fsamp_s1     <= job_q.first;
		if (tap_vld_s1) begin
			acc_q   <= acc_next;
			done_s2 <= done_s1;
		end
		if (sum_vld_s2) begin
			prod_s3 <= PROD_W'(acc_q) * PROD_W'(recip);
			done_s3 <= done_s2;
		end
		if (prod_vld_s3) begin
			res_q.mean_value <= mean;
			res_q.line_done  <= done_s3;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		prod_vld_s3 |-> !res_vld_q)
		else $error("product arrived while result register busy");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tap_vld_s1 && last_s1, sum_vld_s2, prod_vld_s3}))
		else $error("more than one result in flight");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP) |-> (t_q <= two_r))
		else $error("tap counter beyond window");

	a_sweep_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP) |-> !in_flight)
		else $error("tap sweep overlaps previous result");

endmodule

`default_nettype wire
